### hdl/obssr_pkg.sv
// Shared types and constants for the obstacle steering speed ramp.
package obssr_pkg;

   localparam int SENSE_W = 12;
   localparam int FREQ_W  = 14;
   localparam int CSR_W   = 14;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      MODE_FWD   = 3'd0,
      MODE_LEFT  = 3'd1,
      MODE_RIGHT = 3'd2,
      MODE_BACK  = 3'd3,
      MODE_IDLE  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NEW   = 2'd0,
      ACT_RAISE = 2'd1,
      ACT_HOLD  = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_SUM_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_DIFF_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_START_FREQ  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_TOP_FREQ    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_FREQ_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_START_FREQ = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_TOP_FREQ   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_FREQ_STEP  = 3'd7;

   typedef struct packed {
      logic [SENSE_W-1:0] side_right;
      logic [SENSE_W-1:0] front_right;
      logic [SENSE_W-1:0] front_left;
      logic [SENSE_W-1:0] side_left;
   } req_type;

   typedef struct packed {
      logic [1:0]        motion_mode;
      logic [FREQ_W-1:0] step_freq;
      logic [1:0]        action;
   } rsp_type;

   typedef struct packed {
      logic [12:0]       front_sum_limit;
      logic [11:0]       side_diff_limit;
      logic [FREQ_W-1:0] fwd_start_freq;
      logic [FREQ_W-1:0] fwd_top_freq;
      logic [FREQ_W-1:0] fwd_freq_step;
      logic [FREQ_W-1:0] turn_start_freq;
      logic [FREQ_W-1:0] turn_top_freq;
      logic [FREQ_W-1:0] turn_freq_step;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [FREQ_W-1:0] freq;
      action_type        action;
   } decide_type;

endpackage

### hdl/obssr_decide.sv
// Mode selection and frequency ramp for one sensor sample.
module obssr_decide import obssr_pkg::*; (
   input  req_type           sample,
   input  mode_type          mode,
   input  logic [FREQ_W-1:0] freq,
   input  cfg_type           cfg,
   output decide_type        result
);

   logic [12:0]       front_sum;
   logic [12:0]       left_bound;
   logic [12:0]       right_bound;
   logic              fwd_ok;
   logic              left_ok;
   logic              right_ok;
   logic [FREQ_W:0]   fwd_raised;
   logic [FREQ_W:0]   turn_raised;
   logic              fwd_fits;
   logic              turn_fits;

   always_comb begin
      front_sum   = {1'b0, sample.front_left} + {1'b0, sample.front_right};
      // signed side difference > limit, rewritten as unsigned a > b + limit
      left_bound  = {1'b0, sample.side_left} + {1'b0, cfg.side_diff_limit};
      right_bound = {1'b0, sample.side_right} + {1'b0, cfg.side_diff_limit};
      fwd_ok      = front_sum <= cfg.front_sum_limit;
      left_ok     = {1'b0, sample.side_right} > left_bound;
      right_ok    = {1'b0, sample.side_left} > right_bound;
      fwd_raised  = {1'b0, freq} + {1'b0, cfg.fwd_freq_step};
      turn_raised = {1'b0, freq} + {1'b0, cfg.turn_freq_step};
      fwd_fits    = fwd_raised <= {1'b0, cfg.fwd_top_freq};
      turn_fits   = turn_raised <= {1'b0, cfg.turn_top_freq};
   end

   always_comb begin
      result.mode   = mode;
      result.freq   = freq;
      result.action = ACT_HOLD;
      priority if (mode == MODE_FWD && fwd_ok) begin
         if (fwd_fits) begin
            result.freq   = fwd_raised[FREQ_W-1:0];
            result.action = ACT_RAISE;
         end
      end else if ((mode == MODE_LEFT && left_ok) || (mode == MODE_RIGHT && right_ok)) begin
         if (turn_fits) begin
            result.freq   = turn_raised[FREQ_W-1:0];
            result.action = ACT_RAISE;
         end
      end else begin
         result.action = ACT_NEW;
         priority if (fwd_ok) begin
            result.mode = MODE_FWD;
            result.freq = cfg.fwd_start_freq;
         end else if (left_ok) begin
            result.mode = MODE_LEFT;
            result.freq = cfg.turn_start_freq;
         end else if (right_ok) begin
            result.mode = MODE_RIGHT;
            result.freq = cfg.turn_start_freq;
         end else begin
            result.mode = MODE_BACK;
            result.freq = cfg.fwd_start_freq;
         end
      end
   end

endmodule

### hdl/obstacle_steer_speed_ramp_core.sv
// Top level: sample register, steering decision, command register, settings.
// Requests pass the sample reg, then the command reg. Throughput: one request per
// cycle unless the command output is stalled; mode and frequency update in the same
// cycle as the command reg loads, so back-to-back samples see the prior update.
// Synchronous active-high reset: mode idle, frequency 0, settings to defaults,
// both pipeline stages empty.
module obstacle_steer_speed_ramp_core import obssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic              smp_valid_ff, smp_valid_in;
   req_type           smp_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff;
   mode_type          mode_ff;
   logic [FREQ_W-1:0] freq_ff;
   cfg_type           cfg_ff;
   decide_type        decision;
   logic              advance;
   logic              req_take;

   assign advance      = smp_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = smp_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign smp_valid_in = req_take || (smp_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   obssr_decide u_decide (
      .sample (smp_ff),
      .mode   (mode_ff),
      .freq   (freq_ff),
      .cfg    (cfg_ff),
      .result (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         freq_ff      <= '0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff <= decision.mode;
            freq_ff <= decision.freq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         smp_ff <= req;
      end
      if (advance) begin
         out_ff.motion_mode <= decision.mode[1:0];
         out_ff.step_freq   <= decision.freq;
         out_ff.action      <= decision.action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_sum_limit <= 13'd400;
         cfg_ff.side_diff_limit <= 12'd10;
         cfg_ff.fwd_start_freq  <= 14'd200;
         cfg_ff.fwd_top_freq    <= 14'd1200;
         cfg_ff.fwd_freq_step   <= 14'd40;
         cfg_ff.turn_start_freq <= 14'd200;
         cfg_ff.turn_top_freq   <= 14'd300;
         cfg_ff.turn_freq_step  <= 14'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRONT_SUM_LIMIT: cfg_ff.front_sum_limit <= csr_wdata[12:0];
            CSR_SIDE_DIFF_LIMIT: cfg_ff.side_diff_limit <= csr_wdata[11:0];
            CSR_FWD_START_FREQ:  cfg_ff.fwd_start_freq  <= csr_wdata;
            CSR_FWD_TOP_FREQ:    cfg_ff.fwd_top_freq    <= csr_wdata;
            CSR_FWD_FREQ_STEP:   cfg_ff.fwd_freq_step   <= csr_wdata;
            CSR_TURN_START_FREQ: cfg_ff.turn_start_freq <= csr_wdata;
            CSR_TURN_TOP_FREQ:   cfg_ff.turn_top_freq   <= csr_wdata;
            CSR_TURN_FREQ_STEP:  cfg_ff.turn_freq_step  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

### hdl/obssr_checker.sv
// Port-level checks for the steering core, bound to the top level.
module obssr_checker import obssr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // backward never ramps, it is always a fresh direction
   a_back_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.motion_mode == 2'(MODE_BACK) |-> rsp.action == ACT_NEW)
      else $error("backward command with ramp action");

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("command valid right after reset");

   // nothing queued in the core, so a request cannot be held off
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!reset) && $past(!req_valid) |-> !req_stall)
      else $error("request stalled with empty pipeline");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled command changed");

endmodule

bind obstacle_steer_speed_ramp_core obssr_checker u_obssr_checker (.*);
